### hw/rtl/gss_pkg.sv
// Shared types, codes and reset constants for the glitch sweep sequencer.
package gss_pkg;

    // Sequencer phases of one glitch attempt
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OFF    = 3'd1,
        PH_DELAY  = 3'd2,
        PH_PULSE  = 3'd3,
        PH_WAIT   = 3'd4,
        PH_STROBE = 3'd5,
        PH_AWAIT  = 3'd6
    } phase_t;

    // Run command codes carried in the mode field
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Chip variant codes that mark a successful glitch
    localparam logic [31:0] VARIANT_A = 32'h0005_2832;
    localparam logic [31:0] VARIANT_B = 32'h0005_2840;

    // Configuration register indexes
    localparam logic [2:0] REG_DELAY_BASE  = 3'd0;
    localparam logic [2:0] REG_DELAY_END   = 3'd1;
    localparam logic [2:0] REG_WIDTH_BASE  = 3'd2;
    localparam logic [2:0] REG_WIDTH_END   = 3'd3;
    localparam logic [2:0] REG_POWER_OFF   = 3'd4;
    localparam logic [2:0] REG_PROBE_WAIT  = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [23:0] RST_DELAY_BASE  = 24'd2000;
    localparam logic [23:0] RST_DELAY_END   = 24'd30000;
    localparam logic [15:0] RST_WIDTH_BASE  = 16'd0;
    localparam logic [15:0] RST_WIDTH_END   = 16'd30;
    localparam logic [23:0] RST_POWER_OFF   = 24'd50000;
    localparam logic [23:0] RST_PROBE_WAIT  = 24'd100000;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // One tick request, first field in the highest bits
    typedef struct packed {
        logic        lock_flag;
        logic [31:0] chip_variant;
        logic        check_valid;
        logic [1:0]  mode;
    } in_item_t;

    // One tick result, first field in the highest bits
    typedef struct packed {
        logic        success;
        logic        running;
        logic [15:0] width_now;
        logic [23:0] delay_now;
        logic        check_request;
        logic        probe_clock_low;
        logic        glitch_drive;
        logic        power_enable;
    } out_item_t;

    // Current register settings
    typedef struct packed {
        logic [23:0] delay_base;
        logic [23:0] delay_end;
        logic [15:0] width_base;
        logic [15:0] width_end;
        logic [23:0] power_off;
        logic [23:0] probe_wait;
    } cfg_t;

    // Count reloads caused by a start register write
    typedef struct packed {
        logic        load_delay;
        logic [23:0] delay_val;
        logic        load_width;
        logic [15:0] width_val;
    } cfg_load_t;

endpackage

### hw/rtl/gss_cfg_regs.sv
// Configuration register file with count reload strobes.
module gss_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output gss_pkg::cfg_t                 cfg,
    output gss_pkg::cfg_load_t            cfg_load
);
    import gss_pkg::*;

    cfg_t cfg_reg;

    // Register writes, reset to the documented defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_base  <= RST_DELAY_BASE;
            cfg_reg.delay_end   <= RST_DELAY_END;
            cfg_reg.width_base  <= RST_WIDTH_BASE;
            cfg_reg.width_end   <= RST_WIDTH_END;
            cfg_reg.power_off   <= RST_POWER_OFF;
            cfg_reg.probe_wait  <= RST_PROBE_WAIT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DELAY_BASE:  cfg_reg.delay_base  <= cfg_wdata;
                REG_DELAY_END:   cfg_reg.delay_end   <= cfg_wdata;
                REG_WIDTH_BASE:  cfg_reg.width_base  <= cfg_wdata[15:0];
                REG_WIDTH_END:   cfg_reg.width_end   <= cfg_wdata[15:0];
                REG_POWER_OFF:   cfg_reg.power_off   <= cfg_wdata;
                REG_PROBE_WAIT:  cfg_reg.probe_wait  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // A start register write also reloads the live count
    always_comb begin
        cfg_load.load_delay = cfg_we && (cfg_addr == REG_DELAY_BASE);
        cfg_load.delay_val  = cfg_wdata;
        cfg_load.load_width = cfg_we && (cfg_addr == REG_WIDTH_BASE);
        cfg_load.width_val  = cfg_wdata[15:0];
    end

endmodule

### hw/rtl/gss_in_stage.sv
// Input register holding one accepted tick request.
module gss_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gss_pkg::in_item_t s_item,
    input  logic              pop,
    output logic              item_vld,
    output gss_pkg::in_item_t item
);
    import gss_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    // Free, or emptied in this cycle
    assign s_tready = !vld_reg || pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

### hw/rtl/gss_core.sv
// Sweep state, single-tick phase sequencing and result formation.
module gss_core #(
    parameter int TIMER_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  gss_pkg::in_item_t   item,
    input  gss_pkg::cfg_t       cfg,
    input  gss_pkg::cfg_load_t  cfg_load,
    output gss_pkg::out_item_t  result
);
    import gss_pkg::*;

    localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};
    localparam int SETTLE_STEPS = 5;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [23:0]           delay_reg, delay_next;
    logic [15:0]           width_reg, width_next;
    logic                  run_reg, run_next;
    logic                  found_reg, found_next;

    phase_t                ph_set;

    // Phase length clipped to what the timer can count
    function automatic logic [CW-1:0] clip_len(input logic [23:0] len);
        logic [CW-1:0] len_c;
        logic [CW-1:0] max_c;
        len_c = CW'(len);
        max_c = CW'(TMR_MAX);
        clip_len = (len_c > max_c) ? max_c : len_c;
    endfunction

    // Next state: command, reply, then skip through expired phases
    always_comb begin
        phase_t                ph;
        logic [TIMER_BITS-1:0] tmr;
        logic [23:0]           dcnt;
        logic [15:0]           wcnt;
        logic                  run;
        logic                  found;
        logic                  done;
        logic [23:0]           len;
        logic [16:0]           w_inc;
        logic [24:0]           d_inc;
        logic                  hit;

        ph    = phase_reg;
        tmr   = timer_reg;
        dcnt  = delay_reg;
        wcnt  = width_reg;
        run   = run_reg;
        found = found_reg;
        done  = 1'b0;
        len   = '0;
        w_inc = '0;
        d_inc = '0;
        hit   = (item.chip_variant == VARIANT_A) || (item.chip_variant == VARIANT_B)
                || item.lock_flag;

        if (item.mode == MODE_STOP) begin
            run = 1'b0;
            ph  = PH_IDLE;
            tmr = '0;
        end else begin
            if (item.mode == MODE_START && !run) begin
                run   = 1'b1;
                found = 1'b0;
                ph    = PH_OFF;
                tmr   = '0;
            end
            if (ph == PH_AWAIT && item.check_valid) begin
                if (hit) begin
                    run   = 1'b0;
                    found = 1'b1;
                    ph    = PH_IDLE;
                end else begin
                    ph = PH_OFF;
                end
                tmr = '0;
            end
        end

        // Zero-length phases fall through within the same tick
        for (int i = 0; i < SETTLE_STEPS; i++) begin
            unique case (ph)
                PH_OFF:    len = cfg.power_off;
                PH_DELAY:  len = dcnt;
                PH_PULSE:  len = 24'(wcnt);
                PH_WAIT:   len = cfg.probe_wait;
                PH_STROBE: len = 24'd1;
                default:   done = 1'b1;
            endcase
            if (!done && CW'(tmr) < clip_len(len)) begin
                done = 1'b1;
            end
            if (!done) begin
                if (ph == PH_PULSE) begin
                    w_inc = {1'b0, wcnt} + 17'd1;
                    if (w_inc > {1'b0, cfg.width_end}) begin
                        d_inc = {1'b0, dcnt} + 25'd1;
                        wcnt  = cfg.width_base;
                        dcnt  = (d_inc > {1'b0, cfg.delay_end}) ? cfg.delay_base
                                                                 : d_inc[23:0];
                    end else begin
                        wcnt = w_inc[15:0];
                    end
                end
                ph  = phase_t'(ph + 3'd1);
                tmr = '0;
            end
        end

        ph_set      = ph;
        phase_next  = ph;
        delay_next  = dcnt;
        width_next  = wcnt;
        run_next    = run;
        found_next  = found;

        // Timer runs in the timed phases and holds at full count
        if (ph == PH_OFF || ph == PH_DELAY || ph == PH_PULSE || ph == PH_WAIT
                || ph == PH_STROBE) begin
            timer_next = (tmr == TMR_MAX) ? tmr : tmr + 1'b1;
        end else begin
            timer_next = '0;
        end
    end

    // Result drive decode from the settled phase
    always_comb begin
        result.power_enable    = (ph_set != PH_OFF);
        result.glitch_drive    = (ph_set == PH_PULSE);
        result.probe_clock_low = (ph_set == PH_OFF) || (ph_set == PH_DELAY)
                                 || (ph_set == PH_PULSE) || (ph_set == PH_WAIT);
        result.check_request   = (ph_set == PH_STROBE);
        result.delay_now       = delay_next;
        result.width_now       = width_next;
        result.running         = run_next;
        result.success         = found_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            run_reg   <= 1'b0;
            found_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            run_reg   <= run_next;
            found_reg <= found_next;
        end
    end

    // Sweep counts, reloaded by start register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= RST_DELAY_BASE;
            width_reg <= RST_WIDTH_BASE;
        end else begin
            if (cfg_load.load_delay) begin
                delay_reg <= cfg_load.delay_val;
            end else if (step) begin
                delay_reg <= delay_next;
            end
            if (cfg_load.load_width) begin
                width_reg <= cfg_load.width_val;
            end else if (step) begin
                width_reg <= width_next;
            end
        end
    end

endmodule

### hw/rtl/gss_out_stage.sv
// Result register towards the master side.
module gss_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  gss_pkg::out_item_t result,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output gss_pkg::out_item_t m_item
);
    import gss_pkg::*;

    logic      vld_reg;
    out_item_t item_reg;

    // Room when empty or the held result goes this cycle
    assign can_load = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (can_load) begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_item   = item_reg;

endmodule

### hw/rtl/glitch_sweep_sequencer_unit.sv
// Glitch sweep sequencer top level: input register, sequencer core, result register.
// A request waits in the input register; its result is held in the result register.
// Throughput: one request per cycle while the result register has room; the core
// updates phase, timer and sweep counts together, so each request feeds the next.
// Reset: aresetn is synchronous and active low; it empties both stages, sets
// the phase to idle and loads the registers and counts with their defaults.
module glitch_sweep_sequencer_unit #(
    parameter int TIMER_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request: mode[1:0], check_valid[2], chip_variant[34:3], lock_flag[35]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gss_pkg::IN_DATA_W-1:0]  s_tdata,
    // Result: power_enable[0], glitch_drive[1], probe_clock_low[2],
    // check_request[3], delay_now[27:4], width_now[43:28], running[44], success[45]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gss_pkg::OUT_DATA_W-1:0] m_tdata,
    // Register write port
    input  logic                           cfg_we,
    input  logic [gss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gss_pkg::*;

    in_item_t  s_item;
    in_item_t  item;
    logic      item_vld;
    logic      can_load;
    logic      step;
    out_item_t result;
    out_item_t m_item;
    cfg_t      cfg;
    cfg_load_t cfg_load;

    assign s_item  = s_tdata[$bits(in_item_t)-1:0];
    assign m_tdata = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, m_item};

    // A held request moves on when the result register has room
    assign step = item_vld && can_load;

    gss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg),
        .cfg_load (cfg_load)
    );

    gss_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_item  (s_item),
        .pop     (step),
        .item_vld(item_vld),
        .item    (item)
    );

    gss_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .cfg     (cfg),
        .cfg_load(cfg_load),
        .result  (result)
    );

    gss_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .result  (result),
        .can_load(can_load),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_item  (m_item)
    );

endmodule
